@@ src/m2db_pkg.sv @@
// Shared types, constants and the log2 fraction table for the decibel converter.
// No dependencies; every module of the block imports this package.
package m2db_pkg;

	// Sample and power widths
	localparam int SAMPLE_BITS    = 16;
	localparam int LOG_TABLE_BITS = 5;
	localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;
	localparam int P_BITS         = 2 * SAMPLE_BITS;
	localparam int E_BITS         = $clog2(P_BITS);

	// Log2 in Q16: integer part from the leading one, fraction from the table
	localparam int FRAC_BITS = 16;
	localparam int L_BITS    = E_BITS + FRAC_BITS;

	// 10*log10(2) in Q16, rounded
	localparam int               K_BITS       = 18;
	localparam logic [K_BITS-1:0] TEN_LOG2_Q16 = 18'd197283;

	// Product, level and offset sum widths
	localparam int PROD_BITS  = L_BITS + K_BITS;
	localparam int ROUND_SHFT = 24;
	localparam int LEV_BITS   = PROD_BITS + 1 - ROUND_SHFT;
	localparam int SUM_BITS   = ((LEV_BITS > 16) ? LEV_BITS : 16) + 2;

	// Queue between front and back (depth must be a power of two)
	localparam int Q_DEPTH  = 4;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	// Configuration register indexes
	localparam int                CFG_IDX_W        = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DB_OFFSET    = 4'd1;

	// Queue entry: power word and its zero classification
	typedef struct packed {
		logic              zero;
		logic [P_BITS-1:0] pwr;
	} m2db_pwr_t;

	typedef logic [FRAC_BITS-1:0] frac_tab_t [TABLE_SIZE];

	// floor(65536*log2(1+i/TABLE_SIZE)) by repeated squaring of a Q30 value
	function automatic frac_tab_t build_frac_tab();
		frac_tab_t             t;
		logic [63:0]           x;
		logic [FRAC_BITS-1:0]  r;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			x = 64'(TABLE_SIZE + i) << (30 - LOG_TABLE_BITS);
			r = '0;
			for (int k = 0; k < FRAC_BITS; k++) begin
				x = (x * x) >> 30;
				r = {r[FRAC_BITS-2:0], 1'b0};
				if (x >= 64'h0000_0000_8000_0000) begin
					x = x >> 1;
					r[0] = 1'b1;
				end
			end
			t[i] = r;
		end
		return t;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

@@ src/m2db_front.sv @@
// Front end: takes samples, forms magnitudes, squares and the power word.
// Depends on m2db_pkg; feeds m2db_queue.
module m2db_front
	import m2db_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic                          complex_mode,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	output logic                          pend_s1,
	output logic                          pend_s2,
	output logic                          push,
	output m2db_pwr_t                     push_data
);

	logic [SAMPLE_BITS-1:0] mag_a, mag_b;
	logic [SAMPLE_BITS-1:0] mag_a_s1, mag_b_s1;
	logic                   zero_s1;
	logic                   vld_s1, vld_s2;
	logic [P_BITS-1:0]      pwr_s2;
	logic                   zero_s2;

	// Absolute values; imaginary part dropped in real mode
	always_comb begin
		mag_a = sample_re[SAMPLE_BITS-1] ? (~sample_re + 1'b1) : sample_re;
		mag_b = '0;
		if (complex_mode) begin
			mag_b = sample_im[SAMPLE_BITS-1] ? (~sample_im + 1'b1) : sample_im;
		end
	end

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: magnitudes and zero classification
	always_ff @(posedge clk) begin
		if (take) begin
			mag_a_s1 <= mag_a;
			mag_b_s1 <= mag_b;
			zero_s1  <= (mag_a == '0) && (mag_b == '0);
		end
	end

	// Stage 2: power = a^2 + b^2 (cannot overflow P_BITS)
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			pwr_s2  <= P_BITS'(mag_a_s1 * mag_a_s1) + P_BITS'(mag_b_s1 * mag_b_s1);
			zero_s2 <= zero_s1;
		end
	end

	assign pend_s1        = vld_s1;
	assign pend_s2        = vld_s2;
	assign push           = vld_s2;
	assign push_data.zero = zero_s2;
	assign push_data.pwr  = pwr_s2;

endmodule

@@ src/m2db_queue.sv @@
// Short FIFO of power words between the front end and the log back end.
// Depends on m2db_pkg.
module m2db_queue
	import m2db_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  m2db_pwr_t          push_data,
	input  logic               pop,
	output logic               head_vld,
	output m2db_pwr_t          head_data,
	output logic [Q_CNT_W-1:0] fill
);

	m2db_pwr_t          mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_pop;

	assign do_pop = pop && (cnt_q != '0);

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	assign head_vld  = (cnt_q != '0);
	assign head_data = mem_q[rd_ptr_q];
	assign fill      = cnt_q;

endmodule

@@ src/m2db_back.sv @@
// Back end: leading-one log2, fraction table, dB scaling, offset and saturation.
// Depends on m2db_pkg; drains m2db_queue every cycle.
module m2db_back
	import m2db_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  m2db_pwr_t          in_data,
	input  logic signed [15:0] db_offset,
	output logic               pop,
	output logic               done,
	output logic signed [15:0] level_db,
	output logic               is_floor
);

	localparam logic signed [SUM_BITS-1:0] LVL_MAX = SUM_BITS'(32767);
	localparam logic signed [SUM_BITS-1:0] LVL_MIN = SUM_BITS'(-32768);

	logic [E_BITS-1:0]                e_lod;
	logic [P_BITS+LOG_TABLE_BITS-1:0] ext;
	logic                             vld_s1, vld_s2, vld_s3;
	logic [E_BITS-1:0]                e_s1;
	logic [LOG_TABLE_BITS-1:0]        idx_s1;
	logic                             zero_s1, zero_s2, zero_s3;
	logic [L_BITS-1:0]                lq_s2;
	logic [PROD_BITS-1:0]             prod_s3;
	logic [PROD_BITS:0]               rnd;
	logic [LEV_BITS-1:0]              lev;
	logic signed [SUM_BITS-1:0]       sum;
	logic signed [15:0]               sat;
	logic                             done_q, floor_q;
	logic signed [15:0]               level_q;

	assign pop = in_vld;

	// Leading-one position of the power word
	always_comb begin
		e_lod = '0;
		for (int i = 0; i < P_BITS; i++) begin
			if (in_data.pwr[i]) e_lod = E_BITS'(i);
		end
	end

	// Bits just below the leading one, zero filled for short powers
	assign ext = {in_data.pwr, {LOG_TABLE_BITS{1'b0}}} >> e_lod;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	// Stage 1: exponent and table index
	always_ff @(posedge clk) begin
		if (in_vld) begin
			e_s1    <= e_lod;
			idx_s1  <= ext[LOG_TABLE_BITS-1:0];
			zero_s1 <= in_data.zero;
		end
	end

	// Stage 2: log2 in Q16
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			lq_s2   <= {e_s1, FRAC_TAB[idx_s1]};
			zero_s2 <= zero_s1;
		end
	end

	// Stage 3: scale to dB
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			prod_s3 <= PROD_BITS'(lq_s2 * TEN_LOG2_Q16);
			zero_s3 <= zero_s2;
		end
	end

	// Round half up, add offset, clamp
	always_comb begin
		rnd = {1'b0, prod_s3} + (PROD_BITS+1)'(1 << (ROUND_SHFT - 1));
		lev = rnd[PROD_BITS:ROUND_SHFT];
		sum = $signed(SUM_BITS'(lev)) + SUM_BITS'(db_offset);
		if (sum > LVL_MAX) sat = 16'sh7FFF;
		else if (sum < LVL_MIN) sat = -16'sh8000;
		else sat = sum[15:0];
	end

	// Result register
	always_ff @(posedge clk) begin
		if (vld_s3) begin
			level_q <= zero_s3 ? -16'sh8000 : sat;
			floor_q <= zero_s3;
		end
	end

	assign done     = done_q;
	assign level_db = level_q;
	assign is_floor = floor_q;

endmodule

@@ src/magnitude_to_decibel.sv @@
// Sample magnitude to decibel level: config registers, front, queue and back.
// Depends on m2db_pkg, m2db_front, m2db_queue and m2db_back.
// Throughput: one sample per clock; the result strobe done comes through the two front stages,
// the queue and four back stages (back stages 1 to 3 and the result register).
// The back end drains the queue every cycle and the receiver cannot stall, so busy stays low.
// Reset: asynchronous, clears pipeline valids and queue; complex_mode = 1, db_offset = 0.
module magnitude_to_decibel
	import m2db_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [15:0]                   cfg_data,
	output logic                          done,
	output logic signed [15:0]            level_db,
	output logic                          is_floor
);

	logic               complex_mode_q;
	logic signed [15:0] db_offset_q;
	logic               take;
	logic               pend_s1, pend_s2;
	logic               push, pop, head_vld;
	m2db_pwr_t          push_data, head_data;
	logic [Q_CNT_W-1:0] fill;
	logic [Q_CNT_W:0]   credit_used;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			complex_mode_q <= 1'b1;
			db_offset_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COMPLEX_MODE: complex_mode_q <= cfg_data[0];
				CFG_DB_OFFSET:    db_offset_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Hold off new samples when the queue could not absorb those in flight
	assign credit_used = (Q_CNT_W+1)'(fill) + (Q_CNT_W+1)'(pend_s1) + (Q_CNT_W+1)'(pend_s2);
	assign busy        = (credit_used >= (Q_CNT_W+1)'(Q_DEPTH));
	assign take        = start && !busy;

	m2db_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.complex_mode (complex_mode_q),
		.sample_re    (sample_re),
		.sample_im    (sample_im),
		.pend_s1      (pend_s1),
		.pend_s2      (pend_s2),
		.push         (push),
		.push_data    (push_data)
	);

	m2db_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_vld  (head_vld),
		.head_data (head_data),
		.fill      (fill)
	);

	m2db_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (head_vld),
		.in_data   (head_data),
		.db_offset (db_offset_q),
		.pop       (pop),
		.done      (done),
		.level_db  (level_db),
		.is_floor  (is_floor)
	);

endmodule
